// ===== rtl/fmh_pkg.sv =====
package fmh_pkg;

  localparam int unsigned Channels   = 64;
  localparam int unsigned Bins       = 4096;
  localparam int unsigned CountWidth = 32;

  localparam logic [31:0] HeaderReset = 32'hffffea0c;
  localparam int unsigned SkipWords   = 2;
  localparam int unsigned SampleWidth = 16;

  localparam int unsigned WordWidth    = 32;
  localparam int unsigned ChanWidth    = 6;
  localparam int unsigned BinIdxWidth  = 13;
  localparam int unsigned ResultWidth  = 32;
  localparam int unsigned InDataWidth  = 56;

  localparam logic OpStream = 1'b0;
  localparam logic OpRead   = 1'b1;

  // request flags moving from the framer into the store pipeline
  typedef struct packed {
    logic valid;
    logic rd;    // read one bin, else bump one bin
    logic ovf;   // target is the overflow entry of the channel
    logic zero;  // read outside the histogram, answer is zero
  } req_t;

endpackage

// ===== rtl/fmh_framer.sv =====
module fmh_framer #(
  parameter int unsigned CHANNELS = fmh_pkg::Channels,
  parameter int unsigned BINS     = fmh_pkg::Bins,
  localparam int unsigned CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned BINW    = $clog2(BINS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmh_pkg::WordWidth-1:0]     cfg_wdata_i,
  input  logic                              accept_i,
  input  logic                              op_i,
  input  logic [fmh_pkg::WordWidth-1:0]     word_i,
  input  logic [fmh_pkg::ChanWidth-1:0]     rd_ch_i,
  input  logic [fmh_pkg::BinIdxWidth-1:0]   rd_bin_i,
  output fmh_pkg::req_t                     req_o,
  output logic [CHW-1:0]                    req_ch_o,
  output logic [BINW-1:0]                   req_bin_o
);

  localparam logic [1:0] PhHunt   = 2'd0;
  localparam logic [1:0] PhSkip   = 2'd1;
  localparam logic [1:0] PhSample = 2'd2;

  logic [fmh_pkg::WordWidth-1:0]   header_q;
  logic [1:0]                      phase_q, phase_d;
  logic [CHW-1:0]                  pos_q, pos_d;
  logic [fmh_pkg::SampleWidth-1:0] sample;
  logic [7:0]                      rd_ch_ext;
  logic [15:0]                     rd_bin_ext;

  assign sample     = word_i[fmh_pkg::SampleWidth-1:0];
  assign rd_ch_ext  = 8'(rd_ch_i);
  assign rd_bin_ext = 16'(rd_bin_i);

  always_comb begin
    req_o     = '0;
    req_ch_o  = pos_q;
    req_bin_o = sample[BINW-1:0];
    if (op_i == fmh_pkg::OpRead) begin
      req_o.valid = accept_i;
      req_o.rd    = 1'b1;
      req_o.zero  = (32'(rd_ch_i) >= CHANNELS) || (32'(rd_bin_i) > BINS);
      req_o.ovf   = (32'(rd_bin_i) == BINS);
      req_ch_o    = rd_ch_ext[CHW-1:0];
      req_bin_o   = rd_bin_ext[BINW-1:0];
    end else begin
      req_o.valid = accept_i && (phase_q == PhSample);
      req_o.ovf   = (32'(sample) >= BINS);
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    if (accept_i && (op_i == fmh_pkg::OpStream)) begin
      case (phase_q)
        PhHunt: begin
          if (word_i == header_q) begin
            phase_d = PhSkip;
            pos_d   = '0;
          end
        end
        PhSkip: begin
          if (pos_q == CHW'(fmh_pkg::SkipWords - 1)) begin
            phase_d = PhSample;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        PhSample: begin
          if (pos_q == CHW'(CHANNELS - 1)) begin
            phase_d = PhHunt;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        default: begin
          phase_d = PhHunt;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= fmh_pkg::HeaderReset;
      phase_q  <= PhHunt;
      pos_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== rtl/fmh_store.sv =====
module fmh_store #(
  parameter int unsigned CHANNELS    = fmh_pkg::Channels,
  parameter int unsigned BINS        = fmh_pkg::Bins,
  parameter int unsigned COUNT_WIDTH = fmh_pkg::CountWidth,
  localparam int unsigned CHW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned BINW       = $clog2(BINS),
  localparam int unsigned AW         = CHW + BINW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  fmh_pkg::req_t          req_i,
  input  logic [CHW-1:0]         req_ch_i,
  input  logic [BINW-1:0]        req_bin_i,
  output logic                   ready_o,
  output fmh_pkg::req_t          s1_o,
  output logic [COUNT_WIDTH-1:0] count_o
);

  localparam int unsigned Depth = CHANNELS << BINW;

  logic [COUNT_WIDTH-1:0] bin_mem [Depth];
  logic [COUNT_WIDTH-1:0] ovf_mem [CHANNELS];

  logic                   clr_active_q;
  logic [AW-1:0]          clr_addr_q;

  fmh_pkg::req_t          s1_q;
  logic [AW-1:0]          s1_addr_q;
  logic [CHW-1:0]         s1_ch_q;
  logic [COUNT_WIDTH-1:0] bin_rd_q, ovf_rd_q;

  // last write to each memory, forwarded over the read-before-write slot
  logic                   lwb_valid_q, lwo_valid_q;
  logic [AW-1:0]          lwb_addr_q;
  logic [CHW-1:0]         lwo_addr_q;
  logic [COUNT_WIDTH-1:0] lwb_data_q, lwo_data_q;

  logic [AW-1:0]          req_addr;
  logic [COUNT_WIDTH-1:0] bin_cur, ovf_cur, bin_inc, ovf_inc;
  logic                   bump;
  logic                   bin_we, ovf_we;
  logic [AW-1:0]          bin_wa;
  logic [CHW-1:0]         ovf_wa;
  logic [COUNT_WIDTH-1:0] bin_wd, ovf_wd;

  assign req_addr = {req_ch_i, req_bin_i};
  assign ready_o  = !clr_active_q;
  assign s1_o     = s1_q;

  assign bin_cur = (lwb_valid_q && (lwb_addr_q == s1_addr_q)) ? lwb_data_q : bin_rd_q;
  assign ovf_cur = (lwo_valid_q && (lwo_addr_q == s1_ch_q)) ? lwo_data_q : ovf_rd_q;
  assign bin_inc = (&bin_cur) ? bin_cur : bin_cur + COUNT_WIDTH'(1);
  assign ovf_inc = (&ovf_cur) ? ovf_cur : ovf_cur + COUNT_WIDTH'(1);

  assign bump   = adv_i && s1_q.valid && !s1_q.rd;
  assign bin_we = clr_active_q || (bump && !s1_q.ovf);
  assign ovf_we = clr_active_q ? (clr_addr_q < AW'(CHANNELS)) : (bump && s1_q.ovf);
  assign bin_wa = clr_active_q ? clr_addr_q : s1_addr_q;
  assign ovf_wa = clr_active_q ? clr_addr_q[CHW-1:0] : s1_ch_q;
  assign bin_wd = clr_active_q ? '0 : bin_inc;
  assign ovf_wd = clr_active_q ? '0 : ovf_inc;

  always_comb begin
    if (s1_q.zero) begin
      count_o = '0;
    end else if (s1_q.ovf) begin
      count_o = ovf_cur;
    end else begin
      count_o = bin_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == AW'(Depth - 1)) begin
        clr_active_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      lwb_valid_q <= 1'b0;
      lwo_valid_q <= 1'b0;
    end else begin
      if (adv_i) begin
        s1_q <= req_i;
      end
      if (bin_we) begin
        lwb_valid_q <= 1'b1;
      end
      if (ovf_we) begin
        lwo_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_addr_q <= req_addr;
      s1_ch_q   <= req_ch_i;
    end
    if (bin_we) begin
      lwb_addr_q <= bin_wa;
      lwb_data_q <= bin_wd;
    end
    if (ovf_we) begin
      lwo_addr_q <= ovf_wa;
      lwo_data_q <= ovf_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bin_rd_q <= bin_mem[req_addr];
    end
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ovf_rd_q <= ovf_mem[req_ch_i];
    end
    if (ovf_we) begin
      ovf_mem[ovf_wa] <= ovf_wd;
    end
  end

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_q.valid)
    else $error("item in pipeline during clear pass");

  a_bump_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump && !clr_active_q) |-> ((s1_q.ovf ? ovf_wd : bin_wd) != '0))
    else $error("bump wrote a zero count");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv_i && s1_q.valid) |=> (s1_q.rd && $stable(s1_addr_q) && $stable(bin_rd_q)))
    else $error("stalled read lost its slot");

endmodule

// ===== rtl/framed_multichannel_histogrammer_unit.sv =====
// Framed pulse-height histogrammer. Takes one beat per cycle: stream beats
// (tuser 0) walk the header/skip/sample framing and bump a bin or overflow
// count through a read-modify-write on synchronous memories, with the last
// write forwarded so back-to-back hits on one bin stay exact. Read beats
// (tuser 1) put one count on the master side at the edge after acceptance.
// The input stalls only while a read waits on a full output register that
// is not being taken.
// After reset the memories are swept to zero, one entry per cycle, for
// CHANNELS * 2^ceil(log2(BINS)) cycles (262144 at defaults); s_axis_tready
// stays low during that sweep while header writes are still taken.
module framed_multichannel_histogrammer_unit #(
  parameter int unsigned CHANNELS    = fmh_pkg::Channels,
  parameter int unsigned BINS        = fmh_pkg::Bins,
  parameter int unsigned COUNT_WIDTH = fmh_pkg::CountWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmh_pkg::WordWidth-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_word[31:0], read_channel[37:32], read_bin[50:38], zero pad
  input  logic [fmh_pkg::InDataWidth-1:0]   s_axis_tdata,
  // operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bin_count[31:0]
  output logic [fmh_pkg::ResultWidth-1:0]   m_axis_tdata
);

  localparam int unsigned CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned BINW = $clog2(BINS);

  fmh_pkg::req_t          req, s1;
  logic [CHW-1:0]         req_ch;
  logic [BINW-1:0]        req_bin;
  logic                   store_ready;
  logic                   adv;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] count;
  logic                   out_valid_q;
  logic [fmh_pkg::ResultWidth-1:0] out_data_q;

  assign adv           = !(s1.valid && s1.rd) || !out_valid_q || m_axis_tready;
  assign s_axis_tready = store_ready && adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  fmh_framer #(
    .CHANNELS(CHANNELS),
    .BINS    (BINS)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .op_i       (s_axis_tuser),
    .word_i     (s_axis_tdata[31:0]),
    .rd_ch_i    (s_axis_tdata[37:32]),
    .rd_bin_i   (s_axis_tdata[50:38]),
    .req_o      (req),
    .req_ch_o   (req_ch),
    .req_bin_o  (req_bin)
  );

  fmh_store #(
    .CHANNELS   (CHANNELS),
    .BINS       (BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .req_i    (req),
    .req_ch_i (req_ch),
    .req_bin_i(req_bin),
    .ready_o  (store_ready),
    .s1_o     (s1),
    .count_o  (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1.valid && s1.rd) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1.valid && s1.rd) begin
      out_data_q <= fmh_pkg::ResultWidth'(count);
    end
  end

endmodule
